>>> hdl/bpc_pkg.sv
package bpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int CNT_W             = 7;

    localparam int SQ_LAST     = 2;
    localparam int SQRT_LAST   = 19;
    localparam int PROD_LAST   = 3;
    localparam int DIV_LAST    = 31;
    localparam int CORDIC_LAST = 15;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_OOR     = 2'd2;

    localparam logic [1:0] CFG_VEL  = 2'd0;
    localparam logic [1:0] CFG_MASS = 2'd1;
    localparam logic [1:0] CFG_GRAV = 2'd2;

    localparam logic [15:0] VEL_RST  = 16'd6400;
    localparam logic [15:0] MASS_RST = 16'd210;
    localparam logic [15:0] GRAV_RST = 16'd2509;

    localparam int HALF_PI_Q16    = 102944;
    localparam int PI_Q16         = 205887;
    localparam int RAD_TO_DEG_Q16 = 3754936;
    localparam int DEG_MAX_Q16    = 5898240;
    localparam int RECIP_1000     = 1073742;  // ceil(2^30/1000), exact for 20-bit ranges
    localparam int MM2_X2         = 2000000;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQRT, S_RDIV, S_VSQ, S_DMUL, S_SCAN, S_CHECK,
        S_CMG1, S_CMG2, S_PROD, S_DIVI, S_DIV, S_EINIT, S_ELEV, S_CINIT,
        S_COMP, S_DEG, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQ, OP_SQRT, OP_RDIV, OP_VSQ, OP_DMUL, OP_SCAN,
        OP_CMG1, OP_CMG2, OP_PROD, OP_DIVI, OP_DIV, OP_EINIT, OP_CORDIC,
        OP_CINIT, OP_DEG, OP_OUT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       status;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic found;
        logic sat;
    } t_dp_stat;

    function automatic logic [16:0] atan_q16(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30386;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            4'd15:   v = 17'd2;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/ballistic_pitch_compensator_core.sv
// Ballistic pitch compensator.
// Input channel (i_valid/o_ready): one transaction is either a table write
// (i_req_type=1: slot, key in whole metres, Q8.8 coefficient) or an aim
// request (i_req_type=0: target x/y/z in mm). Writes finish in the accept
// cycle and return nothing; slots beyond the table are dropped.
// Output channel (o_valid/i_ready): one transaction per aim request with
// pitch (Q3.16 rad), compensation (Q7.16 deg), horizontal range (mm), status.
// Config channel (i_cfg_valid/o_cfg_ready): always ready; index 0 velocity,
// 1 mass, 2 gravity; other indexes ignored. Write only while idle.
// Sequence: three squares, the 20-step square root, the one-entry-per-cycle
// table scan, the 32-step divider (skipped when the quotient saturates) and
// two 16-step CORDIC passes; an invalid or out-of-range status goes from the
// table check straight to the result. The multiplications share one 32x24
// multiplier. Only one aim is in flight: the next request is accepted in the
// cycle after the previous result enters the output register.
// If the receiver stalls, a finished result waits there and the sequencer
// holds in its final state.
// Reset: control and configuration registers return to their defaults, all table slots become invalid.
module ballistic_pitch_compensator_core #(
    parameter int TABLE_ENTRIES = bpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic signed [19:0] i_target_x,
    input  logic signed [19:0] i_target_y,
    input  logic signed [19:0] i_target_z,
    input  logic [2:0]         i_entry_index,
    input  logic [9:0]         i_entry_range,
    input  logic [15:0]        i_entry_coef,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [18:0] o_pitch,
    output logic [22:0]        o_comp_degrees,
    output logic [19:0]        o_range_out,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    bpc_pkg::t_dp_cmd  cmd;
    bpc_pkg::t_dp_stat stat;

    // config writes never stall
    assign o_cfg_ready = 1'b1;

    bpc_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // datapath: squares, root, table scan, divider, CORDIC, output register
    bpc_dpath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_z     (i_target_z),
        .i_entry_index  (i_entry_index),
        .i_entry_range  (i_entry_range),
        .i_entry_coef   (i_entry_coef),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_pitch        (o_pitch),
        .o_comp_degrees (o_comp_degrees),
        .o_range_out    (o_range_out),
        .o_status       (o_status)
    );

endmodule

>>> hdl/bpc_ctrl.sv
module bpc_ctrl #(
    parameter int TABLE_ENTRIES = bpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_req_type,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output bpc_pkg::t_dp_cmd   o_cmd,
    input  bpc_pkg::t_dp_stat  i_stat
);

    bpc_pkg::t_state               r_state, n_state;
    logic [bpc_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [1:0]                    r_status, n_status;
    logic                          r_ovalid, n_ovalid;
    logic                          accept;
    logic                          fire;

    assign o_ready = (r_state == bpc_pkg::S_IDLE);
    assign o_valid = r_ovalid;
    assign accept  = i_valid && o_ready;
    assign fire    = (r_state == bpc_pkg::S_FIN) && (!r_ovalid || i_ready);

    // next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt + 1'b1;
        n_status = r_status;
        case (r_state)
            bpc_pkg::S_IDLE: begin
                if (accept && !i_req_type) n_state = bpc_pkg::S_SQ;
            end
            bpc_pkg::S_SQ: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::SQ_LAST)) n_state = bpc_pkg::S_SQRT;
            end
            bpc_pkg::S_SQRT: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::SQRT_LAST)) n_state = bpc_pkg::S_RDIV;
            end
            bpc_pkg::S_RDIV: n_state = bpc_pkg::S_VSQ;
            bpc_pkg::S_VSQ:  n_state = bpc_pkg::S_DMUL;
            bpc_pkg::S_DMUL: n_state = bpc_pkg::S_SCAN;
            bpc_pkg::S_SCAN: begin
                if (r_cnt == bpc_pkg::CNT_W'(TABLE_ENTRIES)) n_state = bpc_pkg::S_CHECK;
            end
            bpc_pkg::S_CHECK: begin
                if (i_stat.invalid) begin
                    n_status = bpc_pkg::ST_INVALID;
                    n_state  = bpc_pkg::S_FIN;
                end else if (!i_stat.found) begin
                    n_status = bpc_pkg::ST_OOR;
                    n_state  = bpc_pkg::S_FIN;
                end else begin
                    n_status = bpc_pkg::ST_OK;
                    n_state  = bpc_pkg::S_CMG1;
                end
            end
            bpc_pkg::S_CMG1: n_state = bpc_pkg::S_CMG2;
            bpc_pkg::S_CMG2: n_state = bpc_pkg::S_PROD;
            bpc_pkg::S_PROD: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::PROD_LAST)) n_state = bpc_pkg::S_DIVI;
            end
            bpc_pkg::S_DIVI: begin
                n_state = i_stat.sat ? bpc_pkg::S_EINIT : bpc_pkg::S_DIV;
            end
            bpc_pkg::S_DIV: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::DIV_LAST)) n_state = bpc_pkg::S_EINIT;
            end
            bpc_pkg::S_EINIT: n_state = bpc_pkg::S_ELEV;
            bpc_pkg::S_ELEV: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::CORDIC_LAST)) n_state = bpc_pkg::S_CINIT;
            end
            bpc_pkg::S_CINIT: n_state = bpc_pkg::S_COMP;
            bpc_pkg::S_COMP: begin
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::CORDIC_LAST)) n_state = bpc_pkg::S_DEG;
            end
            bpc_pkg::S_DEG: n_state = bpc_pkg::S_FIN;
            bpc_pkg::S_FIN: begin
                if (fire) n_state = bpc_pkg::S_IDLE;
            end
            default: n_state = bpc_pkg::S_IDLE;
        endcase
        if (n_state != r_state) n_cnt = '0;
    end

    // commands
    always_comb begin
        o_cmd.cnt    = r_cnt;
        o_cmd.status = r_status;
        case (r_state)
            bpc_pkg::S_IDLE:  o_cmd.op = accept ? bpc_pkg::OP_LOAD : bpc_pkg::OP_NONE;
            bpc_pkg::S_SQ:    o_cmd.op = bpc_pkg::OP_SQ;
            bpc_pkg::S_SQRT:  o_cmd.op = bpc_pkg::OP_SQRT;
            bpc_pkg::S_RDIV:  o_cmd.op = bpc_pkg::OP_RDIV;
            bpc_pkg::S_VSQ:   o_cmd.op = bpc_pkg::OP_VSQ;
            bpc_pkg::S_DMUL:  o_cmd.op = bpc_pkg::OP_DMUL;
            bpc_pkg::S_SCAN:  o_cmd.op = bpc_pkg::OP_SCAN;
            bpc_pkg::S_CMG1:  o_cmd.op = bpc_pkg::OP_CMG1;
            bpc_pkg::S_CMG2:  o_cmd.op = bpc_pkg::OP_CMG2;
            bpc_pkg::S_PROD:  o_cmd.op = bpc_pkg::OP_PROD;
            bpc_pkg::S_DIVI:  o_cmd.op = bpc_pkg::OP_DIVI;
            bpc_pkg::S_DIV:   o_cmd.op = bpc_pkg::OP_DIV;
            bpc_pkg::S_EINIT: o_cmd.op = bpc_pkg::OP_EINIT;
            bpc_pkg::S_ELEV:  o_cmd.op = bpc_pkg::OP_CORDIC;
            bpc_pkg::S_CINIT: o_cmd.op = bpc_pkg::OP_CINIT;
            bpc_pkg::S_COMP:  o_cmd.op = bpc_pkg::OP_CORDIC;
            bpc_pkg::S_DEG:   o_cmd.op = bpc_pkg::OP_DEG;
            bpc_pkg::S_FIN:   o_cmd.op = fire ? bpc_pkg::OP_OUT : bpc_pkg::OP_NONE;
            default:          o_cmd.op = bpc_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && !i_ready;
        if (fire) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpc_pkg::S_IDLE;
            r_cnt    <= '0;
            r_status <= bpc_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_status <= n_status;
            r_ovalid <= n_ovalid;
        end
    end

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type) |=> (r_state == bpc_pkg::S_IDLE))
        else $error("table write left idle");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_ready && !fire) |=> !r_ovalid)
        else $error("result not retired");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpc_pkg::S_DIV) |-> (r_cnt <= bpc_pkg::CNT_W'(bpc_pkg::DIV_LAST)))
        else $error("divider overran");

    a_ok_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpc_pkg::S_CMG1) |-> (i_stat.found && !i_stat.invalid
                                          && r_status == bpc_pkg::ST_OK))
        else $error("compensation started without a table match");

endmodule

>>> hdl/bpc_dpath.sv
module bpc_dpath #(
    parameter int TABLE_ENTRIES = bpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_req_type,
    input  logic signed [19:0]  i_target_x,
    input  logic signed [19:0]  i_target_y,
    input  logic signed [19:0]  i_target_z,
    input  logic [2:0]          i_entry_index,
    input  logic [9:0]          i_entry_range,
    input  logic [15:0]         i_entry_coef,
    input  bpc_pkg::t_dp_cmd    i_cmd,
    output bpc_pkg::t_dp_stat   o_stat,
    output logic signed [18:0]  o_pitch,
    output logic [22:0]         o_comp_degrees,
    output logic [19:0]         o_range_out,
    output logic [1:0]          o_status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic signed [19:0] HALF_PI = 20'(bpc_pkg::HALF_PI_Q16);
    localparam logic signed [19:0] PI      = 20'(bpc_pkg::PI_Q16);

    // configuration
    logic [15:0] r_vel, r_mass, r_grav;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel  <= bpc_pkg::VEL_RST;
            r_mass <= bpc_pkg::MASS_RST;
            r_grav <= bpc_pkg::GRAV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpc_pkg::CFG_VEL:  r_vel  <= i_cfg_data;
                bpc_pkg::CFG_MASS: r_mass <= i_cfg_data;
                bpc_pkg::CFG_GRAV: r_grav <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient table
    logic [9:0]               mem_key  [TABLE_ENTRIES];
    logic [15:0]              mem_coef [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [AW+2:0]            wr_ext;
    logic [AW-1:0]            wr_addr;
    logic                     wr_en;
    logic                     scan_rd;
    logic [AW-1:0]            rd_addr;
    logic [9:0]               r_rd_key;
    logic [15:0]              r_rd_coef;
    logic [AW-1:0]            r_rd_idx;

    assign wr_ext  = (AW + 3)'(i_entry_index);
    assign wr_addr = wr_ext[AW-1:0];
    assign wr_en   = (i_cmd.op == bpc_pkg::OP_LOAD) && i_req_type
                     && (wr_ext < (AW + 3)'(TABLE_ENTRIES));
    assign scan_rd = (i_cmd.op == bpc_pkg::OP_SCAN)
                     && (i_cmd.cnt < bpc_pkg::CNT_W'(TABLE_ENTRIES));
    assign rd_addr = i_cmd.cnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr]  <= i_entry_range;
            mem_coef[wr_addr] <= i_entry_coef;
        end
        if (scan_rd) begin
            r_rd_key  <= mem_key[rd_addr];
            r_rd_coef <= mem_coef[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    // arithmetic state
    logic signed [19:0] r_x, r_y, r_z;
    logic [39:0]        r_sxy, r_s3, r_sqsh;
    logic [21:0]        r_rem_sq;
    logic [19:0]        r_root;
    logic [9:0]         r_range_m;
    logic [31:0]        r_vsq;
    logic [52:0]        r_d;
    logic               r_found;
    logic [9:0]         r_best_key;
    logic [15:0]        r_best_coef;
    logic [47:0]        r_cmg;
    logic [87:0]        r_p;
    logic [52:0]        r_rem;
    logic [31:0]        r_plo;
    logic [31:0]        r_q;
    logic signed [43:0] r_cx, r_cy;
    logic signed [19:0] r_ang;
    logic signed [18:0] r_elev;
    logic signed [18:0] r_pitch;
    logic [22:0]        r_deg;
    logic signed [18:0] r_o_pitch;
    logic [22:0]        r_o_deg;
    logic [19:0]        r_o_range;
    logic [1:0]         r_o_status;

    // shared multiplier
    logic [19:0] abs_x, abs_y, abs_z, abs_sel;
    logic [31:0] m_a;
    logic [23:0] m_b;
    logic [55:0] m_p;
    logic [16:0] comp_cl;

    assign abs_x = r_x[19] ? 20'(-r_x) : 20'(r_x);
    assign abs_y = r_y[19] ? 20'(-r_y) : 20'(r_y);
    assign abs_z = r_z[19] ? 20'(-r_z) : 20'(r_z);
    assign abs_sel = (i_cmd.cnt[1:0] == 2'd0) ? abs_x :
                     (i_cmd.cnt[1:0] == 2'd1) ? abs_y : abs_z;
    assign comp_cl = r_ang[19] ? 17'd0 :
                     (r_ang > HALF_PI) ? 17'(bpc_pkg::HALF_PI_Q16) : r_ang[16:0];

    always_comb begin
        case (i_cmd.op)
            bpc_pkg::OP_SQ: begin
                m_a = 32'(abs_sel);
                m_b = 24'(abs_sel);
            end
            bpc_pkg::OP_RDIV: begin
                m_a = 32'(r_root);
                m_b = 24'(bpc_pkg::RECIP_1000);
            end
            bpc_pkg::OP_VSQ: begin
                m_a = 32'(r_vel);
                m_b = 24'(r_vel);
            end
            bpc_pkg::OP_DMUL: begin
                m_a = r_vsq;
                m_b = 24'(bpc_pkg::MM2_X2);
            end
            bpc_pkg::OP_CMG1: begin
                m_a = 32'(r_best_coef);
                m_b = 24'(r_mass);
            end
            bpc_pkg::OP_CMG2: begin
                m_a = r_cmg[31:0];
                m_b = 24'(r_grav);
            end
            bpc_pkg::OP_PROD: begin
                m_a = i_cmd.cnt[0] ? 32'(r_s3[39:20]) : 32'(r_s3[19:0]);
                m_b = i_cmd.cnt[1] ? r_cmg[47:24] : r_cmg[23:0];
            end
            bpc_pkg::OP_DEG: begin
                m_a = 32'(comp_cl);
                m_b = 24'(bpc_pkg::RAD_TO_DEG_Q16);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = 56'(m_a) * 56'(m_b);

    // partial product placement
    logic [6:0]  pp_sh;
    logic [87:0] pp_term;
    always_comb begin
        case (i_cmd.cnt[1:0])
            2'd0:    pp_sh = 7'd0;
            2'd1:    pp_sh = 7'd20;
            2'd2:    pp_sh = 7'd24;
            default: pp_sh = 7'd44;
        endcase
    end
    assign pp_term = 88'(m_p[43:0]) << pp_sh;

    // square root digit
    logic [23:0] sq_t;
    logic [23:0] sq_trial;
    logic        sq_ge;
    assign sq_t     = {r_rem_sq, r_sqsh[39:38]};
    assign sq_trial = 24'({r_root, 2'b01});
    assign sq_ge    = sq_t >= sq_trial;

    // divider step
    logic [53:0] dv_t;
    logic        dv_ge;
    assign dv_t  = {r_rem, r_plo[31]};
    assign dv_ge = dv_t >= 54'(r_d);

    // CORDIC step
    logic [3:0]         ci;
    logic signed [43:0] dx, dy;
    logic signed [19:0] at;
    assign ci = i_cmd.cnt[3:0];
    assign dx = r_cx >>> ci;
    assign dy = r_cy >>> ci;
    assign at = signed'(20'(bpc_pkg::atan_q16(ci)));

    // scan compare
    logic hit;
    assign hit = (i_cmd.op == bpc_pkg::OP_SCAN) && (i_cmd.cnt != '0)
                 && r_valid[r_rd_idx] && (r_rd_key >= r_range_m)
                 && (!r_found || (r_rd_key < r_best_key));

    // degrees and pitch
    logic [39:0]        deg_sum;
    logic signed [19:0] pitch_sum;
    assign deg_sum   = 40'(m_p[38:0]) + 40'd32768;
    assign pitch_sum = 20'(r_elev) + signed'({3'b000, comp_cl});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_found <= 1'b0;
        end else begin
            if (wr_en) r_valid[wr_addr] <= 1'b1;
            if (i_cmd.op == bpc_pkg::OP_LOAD) r_found <= 1'b0;
            else if (hit) r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_best_key  <= r_rd_key;
            r_best_coef <= r_rd_coef;
        end
        case (i_cmd.op)
            bpc_pkg::OP_LOAD: begin
                r_x <= i_target_x;
                r_y <= i_target_y;
                r_z <= i_target_z;
            end
            bpc_pkg::OP_SQ: begin
                case (i_cmd.cnt[1:0])
                    2'd0: r_sxy <= m_p[39:0];
                    2'd1: r_sxy <= r_sxy + m_p[39:0];
                    default: begin
                        r_s3     <= r_sxy + m_p[39:0];
                        r_sqsh   <= r_sxy;
                        r_rem_sq <= '0;
                        r_root   <= '0;
                    end
                endcase
            end
            bpc_pkg::OP_SQRT: begin
                r_sqsh <= {r_sqsh[37:0], 2'b00};
                if (sq_ge) begin
                    r_rem_sq <= 22'(sq_t - sq_trial);
                    r_root   <= {r_root[18:0], 1'b1};
                end else begin
                    r_rem_sq <= sq_t[21:0];
                    r_root   <= {r_root[18:0], 1'b0};
                end
            end
            bpc_pkg::OP_RDIV: r_range_m <= m_p[39:30];
            bpc_pkg::OP_VSQ:  r_vsq <= m_p[31:0];
            bpc_pkg::OP_DMUL: r_d <= m_p[52:0];
            bpc_pkg::OP_CMG1: r_cmg <= 48'(m_p[31:0]);
            bpc_pkg::OP_CMG2: begin
                r_cmg <= m_p[47:0];
                r_p   <= '0;
            end
            bpc_pkg::OP_PROD: r_p <= r_p + pp_term;
            bpc_pkg::OP_DIVI: begin
                r_rem <= r_p[84:32];
                r_plo <= r_p[31:0];
                r_q   <= '1;
            end
            bpc_pkg::OP_DIV: begin
                r_rem <= dv_ge ? 53'(dv_t - 54'(r_d)) : dv_t[52:0];
                r_plo <= {r_plo[30:0], 1'b0};
                r_q   <= {r_q[30:0], dv_ge};
            end
            bpc_pkg::OP_EINIT: begin
                r_cx  <= signed'({4'b0000, r_root, 20'd0});
                r_cy  <= signed'({{4{r_z[19]}}, r_z, 20'd0});
                r_ang <= '0;
            end
            bpc_pkg::OP_CORDIC: begin
                if (!r_cy[43]) begin
                    r_cx  <= r_cx + dy;
                    r_cy  <= r_cy - dx;
                    r_ang <= r_ang + at;
                end else begin
                    r_cx  <= r_cx - dy;
                    r_cy  <= r_cy + dx;
                    r_ang <= r_ang - at;
                end
            end
            bpc_pkg::OP_CINIT: begin
                if (r_ang > HALF_PI)       r_elev <= 19'(HALF_PI);
                else if (r_ang < -HALF_PI) r_elev <= 19'(-HALF_PI);
                else                       r_elev <= r_ang[18:0];
                r_cx  <= 44'sd16777216;
                r_cy  <= signed'({4'b0000, r_q, 8'd0});
                r_ang <= '0;
            end
            bpc_pkg::OP_DEG: begin
                r_deg <= (deg_sum[39:16] > 24'(bpc_pkg::DEG_MAX_Q16))
                         ? 23'(bpc_pkg::DEG_MAX_Q16) : deg_sum[38:16];
                if (pitch_sum > PI)       r_pitch <= 19'(PI);
                else if (pitch_sum < -PI) r_pitch <= 19'(-PI);
                else                      r_pitch <= pitch_sum[18:0];
            end
            bpc_pkg::OP_OUT: begin
                r_o_pitch  <= (i_cmd.status == bpc_pkg::ST_OK) ? r_pitch : '0;
                r_o_deg    <= (i_cmd.status == bpc_pkg::ST_OK) ? r_deg : '0;
                r_o_range  <= r_root;
                r_o_status <= i_cmd.status;
            end
            default: ;
        endcase
    end

    assign o_stat.invalid = (r_root == '0) || (r_vel == '0);
    assign o_stat.found   = r_found;
    assign o_stat.sat     = r_p[87:32] >= 56'(r_d);

    assign o_pitch        = r_o_pitch;
    assign o_comp_degrees = r_o_deg;
    assign o_range_out    = r_o_range;
    assign o_status       = r_o_status;

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, written to check it is ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic       REQ_AIM   = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;
    localparam int NUM_SLOTS   = 8;
    localparam int SETTLE_CYC  = 150;       // longer than the worst aim latency
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [18:0] pitch;
        logic [22:0]        deg;
        logic [19:0]        rng;
        logic [1:0]         st;
    } t_aim_res;

    typedef struct {
        logic               req;
        logic signed [19:0] x, y, z;
        logic [2:0]         slot;
        logic [9:0]         key;
        logic [15:0]        coef;
        bit                 typed;   // expectation written into the row
        t_aim_res           res;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_req_type = 1'b0;
    logic signed [19:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic [2:0]         i_entry_index = '0;
    logic [9:0]         i_entry_range = '0;
    logic [15:0]        i_entry_coef = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [18:0] o_pitch;
    logic [22:0]        o_comp_degrees;
    logic [19:0]        o_range_out;
    logic [1:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    ballistic_pitch_compensator_core u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- aim predictor: own copy of registers and table ----------------
    logic [15:0] vel_q, mass_q, grav_q;
    logic [9:0]  key_tab [NUM_SLOTS];
    logic [15:0] coef_tab[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_used;

    const longint atan_lut[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};

    t_aim_res aim_q[$];       // results still owed by the block
    int       sender_pct = 0; // percent of cycles the sender sits idle
    int       stall_pct  = 0; // percent of cycles the receiver stalls
    int       errors     = 0;
    int       cycles     = 0;

    function automatic longint int_sqrt(longint n);
        longint root = 0, b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // vectoring rotation; >>> on signed values floors like the hardware shifts
    function automatic longint vector_angle(longint cx, longint cy);
        longint ang = 0, dx, dy;
        for (int i = 0; i < 16; i++) begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy >= 0) begin
                cx += dy; cy -= dx; ang += atan_lut[i];
            end else begin
                cx -= dy; cy += dx; ang -= atan_lut[i];
            end
        end
        return ang;
    endfunction

    function automatic t_aim_res predict_aim(logic signed [19:0] tx, ty, tz);
        t_aim_res r = '0;
        longint x = tx, y = ty, z = tz;
        longint sxy, rng, elev, comp, pit, deg;
        longint unsigned cmg, dd;
        logic [127:0] prod, quo;
        longint q;
        int best = -1;
        sxy = x * x + y * y;
        rng = int_sqrt(sxy);
        r.rng = rng[19:0];
        if (rng == 0 || vel_q == 0) begin
            r.st = bpc_pkg::ST_INVALID;
            return r;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i] && key_tab[i] >= rng / 1000)
                if (best < 0 || key_tab[i] < key_tab[best]) best = i;
        if (best < 0) begin
            r.st = bpc_pkg::ST_OOR;
            return r;
        end
        elev = vector_angle(rng * 1048576, z * 1048576);
        if (elev > bpc_pkg::HALF_PI_Q16) elev = bpc_pkg::HALF_PI_Q16;
        if (elev < -bpc_pkg::HALF_PI_Q16) elev = -bpc_pkg::HALF_PI_Q16;
        cmg  = longint'(coef_tab[best]) * mass_q * grav_q;
        prod = 128'(cmg) * 128'(sxy + z * z);
        dd   = longint'(vel_q) * vel_q * bpc_pkg::MM2_X2;
        quo  = prod / 128'(dd);
        q    = (quo > 128'h0FFFF_FFFF) ? 64'hFFFF_FFFF : longint'(quo[31:0]);
        comp = vector_angle(longint'(1) << 24, q * 256);
        if (comp < 0) comp = 0;
        if (comp > bpc_pkg::HALF_PI_Q16) comp = bpc_pkg::HALF_PI_Q16;
        pit = elev + comp;
        if (pit > bpc_pkg::PI_Q16) pit = bpc_pkg::PI_Q16;
        if (pit < -bpc_pkg::PI_Q16) pit = -bpc_pkg::PI_Q16;
        deg = (comp * bpc_pkg::RAD_TO_DEG_Q16 + 32768) >>> 16;
        if (deg > bpc_pkg::DEG_MAX_Q16) deg = bpc_pkg::DEG_MAX_Q16;
        r.pitch = pit[18:0];
        r.deg   = deg[22:0];
        r.st    = bpc_pkg::ST_OK;
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_aim_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (aim_q.size() == 0) begin
                $error("result with nothing expected: pitch %0d", o_pitch);
                errors++;
            end else begin
                e = aim_q.pop_front();
                if (o_pitch !== e.pitch) begin
                    $error("pitch exp %0d got %0d", e.pitch, o_pitch); errors++;
                end
                if (o_comp_degrees !== e.deg) begin
                    $error("comp_degrees exp %0d got %0d", e.deg, o_comp_degrees); errors++;
                end
                if (o_range_out !== e.rng) begin
                    $error("range_out exp %0d got %0d", e.rng, o_range_out); errors++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status); errors++;
                end
            end
        end
    end

    // receiver backpressure, changed on the falling edge
    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    // one input transaction; prediction is made at the accepting edge.
    // valid stays up after the accept so back-to-back items need no gap;
    // idle cycles or drain() take it down.
    task automatic send(t_row r);
        t_aim_res p;
        while ($urandom_range(99) < sender_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= r.req;
        i_target_x    <= r.x;
        i_target_y    <= r.y;
        i_target_z    <= r.z;
        i_entry_index <= r.slot;
        i_entry_range <= r.key;
        i_entry_coef  <= r.coef;
        do @(posedge i_clk); while (!o_ready);
        if (r.req == REQ_WRITE) begin
            key_tab[r.slot]   = r.key;
            coef_tab[r.slot]  = r.coef;
            slot_used[r.slot] = 1'b1;
        end else begin
            p = r.typed ? r.res : predict_aim(r.x, r.y, r.z);
            aim_q = {aim_q, p};
        end
        @(negedge i_clk);
    endtask

    // drain every owed result, then let the sequencer go quiet
    task automatic drain();
        i_valid <= 1'b0;
        while (aim_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bpc_pkg::CFG_VEL:  vel_q  = val;
            bpc_pkg::CFG_MASS: mass_q = val;
            bpc_pkg::CFG_GRAV: grav_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_row aim_row(logic signed [19:0] x, y, z);
        t_row r = '{default: '0};
        r.req = REQ_AIM; r.x = x; r.y = y; r.z = z;
        return r;
    endfunction

    function automatic t_row write_row(logic [2:0] s, logic [9:0] k, logic [15:0] c);
        t_row r = '{default: '0};
        r.req = REQ_WRITE; r.slot = s; r.key = k; r.coef = c;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic [19:0] rng, logic [1:0] st);
        r.typed = 1'b1;
        r.res   = '{pitch: '0, deg: '0, rng: rng, st: st};
        return r;
    endfunction

    // coordinate: mostly within a few hundred metres, sometimes any 20-bit value
    function automatic logic signed [19:0] rand_coord();
        case ($urandom_range(9))
            0, 1:    return 20'($urandom);
            2:       return '0;
            default: return 20'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    t_row directed[$];
    t_row r;

    initial begin
        vel_q = bpc_pkg::VEL_RST; mass_q = bpc_pkg::MASS_RST; grav_q = bpc_pkg::GRAV_RST;
        slot_used = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: empty-table cases first, then keys, ties and extremes
        directed = {directed, typed_row(aim_row(0, 0, 5000), 20'd0, bpc_pkg::ST_INVALID)};
        directed = {directed, typed_row(aim_row(3000, -4000, 0), 20'd5000, bpc_pkg::ST_OOR)};
        directed = {directed, write_row(3'd0, 10'd1023, 16'h0100)};
        directed = {directed, write_row(3'd1, 10'd5, 16'hFFFF)};
        directed = {directed, write_row(3'd2, 10'd5, 16'h0001)};   // tie, slot 1 wins
        directed = {directed, write_row(3'd7, 10'd0, 16'h0000)};
        directed = {directed, aim_row(3000, 4000, 0)};
        directed = {directed, aim_row(999, 0, -7)};
        directed = {directed, aim_row(20'sh80000, 20'sh80000, 20'sh7FFFF)};
        directed = {directed, aim_row(20'sh7FFFF, 20'sh7FFFF, 20'sh80000)};
        directed = {directed, aim_row(20'sh80000, 0, 0)};
        directed = {directed, aim_row(0, 20'sh7FFFF, 20'sh7FFFF)};
        directed = {directed, aim_row(1, 0, 20'sh80000)};
        directed = {directed, aim_row(-1, -1, 20'sh7FFFF)};
        directed = {directed, aim_row(5999, 0, 1000)};
        directed = {directed, write_row(3'd1, 10'd1023, 16'h0000)};
        directed = {directed, aim_row(4000, 3000, -2500)};
        foreach (directed[i]) send(directed[i]);

        // register extremes, zero velocity and the unused index
        drain();
        write_reg(bpc_pkg::CFG_VEL, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send(typed_row(aim_row(3000, 4000, 100), 20'd5000, bpc_pkg::ST_INVALID));
        drain();
        write_reg(bpc_pkg::CFG_VEL, 16'd1);
        write_reg(bpc_pkg::CFG_MASS, 16'hFFFF);
        write_reg(bpc_pkg::CFG_GRAV, 16'hFFFF);
        send(aim_row(3000, 4000, 100));
        send(aim_row(20'sh80000, 20'sh7FFFF, 0));

        // random part: four traffic shapes, each behind its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            drain();   // sender holds off until every result is back
            case (ph)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 48; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 48; end
                default: begin sender_pct = 37; stall_pct = 37; end
            endcase
            case (ph)
                0: begin
                    write_reg(bpc_pkg::CFG_VEL, bpc_pkg::VEL_RST);
                    write_reg(bpc_pkg::CFG_MASS, bpc_pkg::MASS_RST);
                    write_reg(bpc_pkg::CFG_GRAV, bpc_pkg::GRAV_RST);
                end
                1: begin
                    write_reg(bpc_pkg::CFG_VEL, 16'hFFFF);
                    write_reg(bpc_pkg::CFG_MASS, 16'd0);
                    write_reg(bpc_pkg::CFG_GRAV, 16'd1);
                end
                default: begin
                    write_reg(bpc_pkg::CFG_VEL, 16'($urandom_range(65535, 256)));
                    write_reg(bpc_pkg::CFG_MASS, 16'($urandom));
                    write_reg(bpc_pkg::CFG_GRAV, 16'($urandom));
                end
            endcase
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(99) < 15)
                    r = write_row(3'($urandom), 10'($urandom), 16'($urandom));
                else
                    r = aim_row(rand_coord(), rand_coord(), rand_coord());
                send(r);
            end
        end

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
